// ===== sv/shape_outline_point_walker_macros.svh =====
// ----------------------------------------------------------------------------
// shape outline point walker assertion macros
// shared property wrappers, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SHAPE_OUTLINE_POINT_WALKER_MACROS_SVH
`define SHAPE_OUTLINE_POINT_WALKER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SOPW_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SOPW_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sopw_pkg.sv =====
// ----------------------------------------------------------------------------
// sopw_pkg
// types, constants and helpers shared by the shape outline point walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sopw_pkg;

   localparam int COORD_BITS    = 16;
   localparam int ORIGIN_BITS   = 16;
   localparam int EXT_BITS      = 13;
   localparam int KIND_BITS     = 3;
   localparam int CMP_BITS      = (COORD_BITS > EXT_BITS) ? COORD_BITS : EXT_BITS;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // shape codes, unused codes act as a dot
   localparam logic [KIND_BITS-1:0] SHAPE_DOT  = 3'd0;
   localparam logic [KIND_BITS-1:0] SHAPE_HRUN = 3'd1;
   localparam logic [KIND_BITS-1:0] SHAPE_VRUN = 3'd2;
   localparam logic [KIND_BITS-1:0] SHAPE_DIAG = 3'd3;
   localparam logic [KIND_BITS-1:0] SHAPE_RECT = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHAPE_KIND = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_X   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_Y   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXTENT_W   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXTENT_H   = 3'd4;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   shape_kind;
      logic [ORIGIN_BITS-1:0] origin_x;
      logic [ORIGIN_BITS-1:0] origin_y;
      logic [EXT_BITS-1:0]    extent_w;
      logic [EXT_BITS-1:0]    extent_h;
   } cfg_type;

   // sign-extend or truncate a 16-bit origin to the coordinate width
   function automatic coord_type org_coord(input logic [ORIGIN_BITS-1:0] o);
      return COORD_BITS'($signed(o));
   endfunction

endpackage

// ===== sv/sopw_step.sv =====
// ----------------------------------------------------------------------------
// sopw_step
// successor of a held point on the configured shape
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sopw_step
   import sopw_pkg::*;
(
   input  cfg_type   cfg,
   input  coord_type cur_x,
   input  coord_type cur_y,
   output coord_type nxt_x,
   output coord_type nxt_y
);

   coord_type           ox;
   coord_type           oy;
   logic [CMP_BITS-1:0] dx;
   logic [CMP_BITS-1:0] up;
   logic [CMP_BITS-1:0] dn;
   logic [CMP_BITS-1:0] len_m1;
   logic [CMP_BITS-1:0] w_m1;
   logic [CMP_BITS-1:0] h_m1;

   always_comb begin
      ox = org_coord(cfg.origin_x);
      oy = org_coord(cfg.origin_y);
      dx = CMP_BITS'(coord_type'(cur_x - ox));
      up = CMP_BITS'(coord_type'(cur_y - oy));
      dn = CMP_BITS'(coord_type'(oy - cur_y));
      // zero length acts as one, short sides act as two
      len_m1 = (cfg.extent_w == '0) ? '0 : CMP_BITS'(cfg.extent_w) - 1'b1;
      w_m1   = (cfg.extent_w < EXT_BITS'(2)) ? CMP_BITS'(1)
                                             : CMP_BITS'(cfg.extent_w) - 1'b1;
      h_m1   = (cfg.extent_h < EXT_BITS'(2)) ? CMP_BITS'(1)
                                             : CMP_BITS'(cfg.extent_h) - 1'b1;

      nxt_x = ox;
      nxt_y = oy;
      case (cfg.shape_kind)
         SHAPE_HRUN: begin
            if (dx < len_m1) begin
               nxt_x = cur_x + 1'b1;
               nxt_y = cur_y;
            end
         end
         SHAPE_VRUN: begin
            if (up < len_m1) begin
               nxt_x = cur_x;
               nxt_y = cur_y + 1'b1;
            end
         end
         SHAPE_DIAG: begin
            if (dx < len_m1) begin
               nxt_x = cur_x + 1'b1;
               nxt_y = cur_y + 1'b1;
            end
         end
         SHAPE_RECT: begin
            // clockwise: top rightward, right down, bottom leftward, left up
            if (dn == '0 && dx < w_m1) begin
               nxt_x = cur_x + 1'b1;
               nxt_y = cur_y;
            end else if (dx == w_m1 && dn < h_m1) begin
               nxt_x = cur_x;
               nxt_y = cur_y - 1'b1;
            end else if (dn == h_m1 && dx != '0 && dx <= w_m1) begin
               nxt_x = cur_x - 1'b1;
               nxt_y = cur_y;
            end else if (dx == '0 && dn != '0 && dn <= h_m1) begin
               nxt_x = cur_x;
               nxt_y = cur_y + 1'b1;
            end
         end
         default: begin
            nxt_x = ox;
            nxt_y = oy;
         end
      endcase
   end

endmodule

// ===== sv/shape_outline_point_walker.sv =====
// ----------------------------------------------------------------------------
// shape_outline_point_walker
// emits the lattice points of a dot, run, diagonal or rectangle outline
// ----------------------------------------------------------------------------
// One point leaves per accepted request, and a request can be accepted every
// cycle. A request passes through two registers: the held-point register,
// loaded with the start point (restart, or first request after reset) or the
// successor of the previous point, and the result register, which adds the
// flag telling whether the following step returns to the start point.
// A request reaches the result through those two registers in turn; one successor
// unit feeds both the next held point and the flag, so the rate is set by that one
// unit and the result register, and stalls on the result side hold the request side
// only once both registers are full. Configuration writes are taken at any
// time but are meant for an idle block; they do not restart the walk.
`timescale 1ns / 1ps

module shape_outline_point_walker
   import sopw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // [0] restart, rest zero
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // point_x, point_y
   output logic                     rsp_tlast,  // last_point
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      started_ff, started_in;
   logic      hold_valid_ff, hold_valid_in;
   coord_type cur_x_ff, cur_x_in;
   coord_type cur_y_ff, cur_y_in;
   logic      rsp_valid_ff, rsp_valid_in;
   coord_type rsp_x_ff, rsp_x_in;
   coord_type rsp_y_ff, rsp_y_in;
   logic      rsp_last_ff, rsp_last_in;

   coord_type ox;
   coord_type oy;
   coord_type adv_x;
   coord_type adv_y;
   logic      req_accept;
   logic      hold_move;

   sopw_step u_step (
      .cfg   (cfg_ff),
      .cur_x (cur_x_ff),
      .cur_y (cur_y_ff),
      .nxt_x (adv_x),
      .nxt_y (adv_y)
   );

   assign csr_ready  = 1'b1;
   assign hold_move  = hold_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !hold_valid_ff || hold_move;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_y_ff, rsp_x_ff});
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      ox = org_coord(cfg_ff.origin_x);
      oy = org_coord(cfg_ff.origin_y);

      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SHAPE_KIND: cfg_in.shape_kind = csr_wdata[KIND_BITS-1:0];
            CSR_ORIGIN_X:   cfg_in.origin_x   = csr_wdata[ORIGIN_BITS-1:0];
            CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_wdata[ORIGIN_BITS-1:0];
            CSR_EXTENT_W:   cfg_in.extent_w   = csr_wdata[EXT_BITS-1:0];
            CSR_EXTENT_H:   cfg_in.extent_h   = csr_wdata[EXT_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end

      started_in    = started_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      hold_valid_in = hold_move ? 1'b0 : hold_valid_ff;
      if (req_accept) begin
         started_in    = 1'b1;
         hold_valid_in = 1'b1;
         if (req_tdata[0] || !started_ff) begin
            cur_x_in = ox;
            cur_y_in = oy;
         end else begin
            cur_x_in = adv_x;
            cur_y_in = adv_y;
         end
      end

      // the held point still sits in cur_ff when it moves to the result
      rsp_valid_in = hold_move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_x_in     = hold_move ? cur_x_ff : rsp_x_ff;
      rsp_y_in     = hold_move ? cur_y_ff : rsp_y_ff;
      rsp_last_in  = hold_move ? (adv_x == ox && adv_y == oy) : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shape_kind <= SHAPE_DOT;
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.extent_w   <= EXT_BITS'(2);
         cfg_ff.extent_h   <= EXT_BITS'(2);
         started_ff        <= 1'b0;
         hold_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cfg_ff            <= cfg_in;
         started_ff        <= started_in;
         hold_valid_ff     <= hold_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== sv/sopw_checker.sv =====
// ----------------------------------------------------------------------------
// sopw_checker
// port-level checks on the shape outline point walker, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shape_outline_point_walker_macros.svh"

module sopw_checker
   import sopw_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast
);

   // a stalled result keeps its point and flag
   `SOPW_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // a fresh result only ever comes from a request that passed through the held-point register
   `SOPW_ASSERT_SAME(a_rsp_origin, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "result without request")

   // with the result side open, an accepted request shows up after the held-point and result registers
   `SOPW_ASSERT_NEXT(a_rsp_latency, (req_tvalid && req_tready && rsp_tready) ##1 rsp_tready, rsp_tvalid, "result missing after request")

   // with the result side open the request side never stalls
   `SOPW_ASSERT_SAME(a_req_open, $past(rsp_tready) && rsp_tready && !$past(reset), req_tready, "request stalled with open result side")

endmodule

bind shape_outline_point_walker sopw_checker u_sopw_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the shape outline point walker
// ----------------------------------------------------------------------------
// Requests are sent with random gaps and results are drained with random
// stalls. Each request is predicted from a shadow copy of the shape registers
// and the held point. The run starts with a scripted pass over every shape, the
// coordinate wrap and the odd register values. Random phases follow. Each phase
// waits until the block is idle, rewrites some or all registers and then walks
// the shape, mostly without restarts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import sopw_pkg::*;

   localparam int RANDOM_REQUESTS = 1450;
   localparam int CALM_TAIL       = 150;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int REPORT_LIMIT    = 10;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = CSR_EXTENT_H + 3'd1;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } walk_point_type;

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_op_type;

   typedef struct packed {
      row_op_type               op;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0] val;
      logic                     restart;
      logic                     typed;
      walk_point_type           want;
   } script_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // [0] restart, rest zero
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // [15:0] point_x, [31:16] point_y
   logic                     rsp_tlast;   // last_point
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   // shadow registers and walk state
   logic [KIND_BITS-1:0] shape_kind_q;
   coord_type            org_x_q;
   coord_type            org_y_q;
   logic [EXT_BITS-1:0]  ext_w_q;
   logic [EXT_BITS-1:0]  ext_h_q;
   coord_type            held_x;
   coord_type            held_y;
   bit                   walk_live;

   walk_point_type pending_points[$];
   script_row_type script[$];

   int  mismatches;
   int  points_checked;
   int  requests_sent;
   int  csr_writes;
   int  hush_cycles;
   int  stall_left;
   bit  calm;
   logic [7:0] kinds_seen;

   shape_outline_point_walker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // successor of a point on the configured shape, start point when off it
   function automatic void step_point(input coord_type x, input coord_type y,
                                      output coord_type nx, output coord_type ny);
      int unsigned len;
      int unsigned w;
      int unsigned h;
      coord_type   dx;
      coord_type   up;
      coord_type   dn;
      len = (ext_w_q == 0) ? 1 : ext_w_q;
      w   = (ext_w_q < 2) ? 2 : ext_w_q;
      h   = (ext_h_q < 2) ? 2 : ext_h_q;
      dx  = x - org_x_q;
      up  = y - org_y_q;
      dn  = org_y_q - y;
      nx  = org_x_q;
      ny  = org_y_q;
      case (shape_kind_q)
         SHAPE_HRUN: begin
            if (dx < len - 1) nx = x + 1'b1;
            if (dx < len - 1) ny = y;
         end
         SHAPE_VRUN: begin
            if (up < len - 1) begin
               nx = x;
               ny = y + 1'b1;
            end
         end
         SHAPE_DIAG: begin
            if (dx < len - 1) begin
               nx = x + 1'b1;
               ny = y + 1'b1;
            end
         end
         SHAPE_RECT: begin
            if (dn == 0 && dx < w - 1) begin
               nx = x + 1'b1;
               ny = y;
            end else if (dx == w - 1 && dn < h - 1) begin
               nx = x;
               ny = y - 1'b1;
            end else if (dn == h - 1 && dx >= 1 && dx <= w - 1) begin
               nx = x - 1'b1;
               ny = y;
            end else if (dx == 0 && dn >= 1 && dn <= h - 1) begin
               nx = x;
               ny = y + 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic walk_point_type walk_one(input logic restart);
      coord_type      nx;
      coord_type      ny;
      walk_point_type p;
      if (restart || !walk_live) begin
         held_x    = org_x_q;
         held_y    = org_y_q;
         walk_live = 1'b1;
      end else begin
         step_point(held_x, held_y, nx, ny);
         held_x = nx;
         held_y = ny;
      end
      step_point(held_x, held_y, nx, ny);
      p.x    = held_x;
      p.y    = held_y;
      p.last = (nx == org_x_q && ny == org_y_q);
      return p;
   endfunction

   function automatic void shadow_write(input logic [CSR_IDX_BITS-1:0] idx,
                                        input logic [CSR_DATA_BITS-1:0] val);
      case (idx)
         CSR_SHAPE_KIND: shape_kind_q = val[KIND_BITS-1:0];
         CSR_ORIGIN_X:   org_x_q      = val;
         CSR_ORIGIN_Y:   org_y_q      = val;
         CSR_EXTENT_W:   ext_w_q      = val[EXT_BITS-1:0];
         CSR_EXTENT_H:   ext_h_q      = val[EXT_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic script_row_type csr_row(input logic [CSR_IDX_BITS-1:0] idx,
                                              input logic [CSR_DATA_BITS-1:0] val);
      script_row_type r;
      r     = '0;
      r.op  = ROW_CSR;
      r.idx = idx;
      r.val = val;
      return r;
   endfunction

   function automatic script_row_type req_row(input logic restart);
      script_row_type r;
      r         = '0;
      r.op      = ROW_REQUEST;
      r.restart = restart;
      return r;
   endfunction

   function automatic script_row_type typed_row(input logic restart, input coord_type x,
                                                input coord_type y, input logic last);
      script_row_type r;
      r           = req_row(restart);
      r.typed     = 1'b1;
      r.want.x    = x;
      r.want.y    = y;
      r.want.last = last;
      return r;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_value(input logic [CSR_IDX_BITS-1:0] idx);
      int r;
      r = $urandom_range(0, 19);
      case (idx)
         CSR_SHAPE_KIND: begin
            if (r < 8)       return CSR_DATA_BITS'(SHAPE_RECT);
            else if (r < 17) return CSR_DATA_BITS'($urandom_range(SHAPE_DOT, SHAPE_DIAG));
            else             return CSR_DATA_BITS'($urandom_range(SHAPE_RECT + 1,
                                                                 {KIND_BITS{1'b1}}));
         end
         CSR_ORIGIN_X, CSR_ORIGIN_Y: begin
            // bias toward the wrap points of the coordinate range
            if (r < 4)       return CSR_DATA_BITS'(16'h7FFF - $urandom_range(0, 8));
            else if (r < 8)  return CSR_DATA_BITS'(16'h8000 + $urandom_range(0, 8));
            else if (r < 11) return CSR_DATA_BITS'(16'hFFFF - $urandom_range(0, 8));
            else             return CSR_DATA_BITS'($urandom);
         end
         CSR_EXTENT_W, CSR_EXTENT_H: begin
            if (r < 14)      return CSR_DATA_BITS'($urandom_range(0, 12));
            else if (r < 18) return CSR_DATA_BITS'($urandom_range(13, 300));
            else if (r < 19) return 16'd4096;
            else             return CSR_DATA_BITS'($urandom);
         end
         default: return CSR_DATA_BITS'($urandom);
      endcase
   endfunction

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      shadow_write(idx, val);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(input logic restart, input logic typed,
                               input walk_point_type typed_point);
      walk_point_type p;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_BITS-1){1'b0}}, restart};
      do @(posedge clock); while (!req_tready);
      kinds_seen[shape_kind_q] = 1'b1;
      p = walk_one(restart);
      pending_points.push_back(typed ? typed_point : p);
      requests_sent++;
   endtask

   task automatic idle_requests(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      idle_requests(1);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // new setting for a phase; a rewrite, partial or full, keeps the held point mid-walk
   task automatic retune_shape(input bit partial);
      logic [CSR_IDX_BITS-1:0] idx;
      int                      n;
      if (partial) begin
         n = $urandom_range(1, 2);
         repeat (n) begin
            idx = CSR_IDX_BITS'($urandom_range(CSR_SHAPE_KIND, CSR_EXTENT_H));
            write_csr(idx, pick_value(idx));
         end
      end else begin
         for (int i = CSR_SHAPE_KIND; i <= CSR_EXTENT_H; i++) begin
            write_csr(CSR_IDX_BITS'(i), pick_value(CSR_IDX_BITS'(i)));
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         idx = CSR_IDX_BITS'($urandom_range(CSR_UNUSED, {CSR_IDX_BITS{1'b1}}));
         write_csr(idx, pick_value(idx));
      end
   endtask

   function automatic void flag_point(input string what, input walk_point_type want,
                                      input walk_point_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch at %0t (%s): want x=%h y=%h last=%b, got x=%h y=%h last=%b",
                  $realtime, what, want.x, want.y, want.last, got.x, got.y, got.last);
   endfunction

   always @(posedge clock) begin
      walk_point_type got;
      walk_point_type want;
      string          bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x    = rsp_tdata[COORD_BITS-1:0];
         got.y    = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
         got.last = rsp_tlast;
         if (pending_points.size() == 0) begin
            flag_point("no point expected", '0, got);
         end else begin
            want = pending_points.pop_front();
            bad  = "";
            if (got.x !== want.x)       bad = {bad, " point_x"};
            if (got.y !== want.y)       bad = {bad, " point_y"};
            if (got.last !== want.last) bad = {bad, " last_point"};
            if (bad != "") flag_point({"wrong", bad}, want, got);
            points_checked++;
         end
      end
   end

   // result side stalls in random bursts unless the run is calm
   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         hush_cycles <= 0;
      end else if (hush_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", hush_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         hush_cycles <= hush_cycles + 1;
      end
   end

   initial begin
      int   steps;
      int   stop_at;
      bit   noisy;
      logic restart;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      calm           = 1'b1;
      hush_cycles    = 0;
      mismatches     = 0;
      points_checked = 0;
      requests_sent  = 0;
      csr_writes     = 0;
      kinds_seen     = '0;
      shape_kind_q   = SHAPE_DOT;
      org_x_q        = '0;
      org_y_q        = '0;
      ext_w_q        = 13'd2;
      ext_h_q        = 13'd2;
      held_x         = '0;
      held_y         = '0;
      walk_live      = 1'b0;

      script = '{
         typed_row(1'b0, 16'h0000, 16'h0000, 1'b1),  // first request emits the start point
         typed_row(1'b0, 16'h0000, 16'h0000, 1'b1),
         csr_row(CSR_SHAPE_KIND, CSR_DATA_BITS'(SHAPE_HRUN)),
         csr_row(CSR_ORIGIN_X, 16'h7FFF),
         csr_row(CSR_ORIGIN_Y, 16'h8000),
         csr_row(CSR_EXTENT_W, 16'd3),
         typed_row(1'b1, 16'h7FFF, 16'h8000, 1'b0),
         req_row(1'b0), req_row(1'b0), req_row(1'b0),  // x wraps past the top
         csr_row(CSR_SHAPE_KIND, CSR_DATA_BITS'(SHAPE_VRUN)),
         csr_row(CSR_EXTENT_W, 16'd0),                 // zero length acts as one
         req_row(1'b1), req_row(1'b0),
         csr_row(CSR_SHAPE_KIND, CSR_DATA_BITS'(SHAPE_DIAG)),
         csr_row(CSR_EXTENT_W, 16'd2),
         req_row(1'b0), req_row(1'b0),
         csr_row(CSR_SHAPE_KIND, CSR_DATA_BITS'(SHAPE_RECT)),
         csr_row(CSR_ORIGIN_X, 16'h0000),
         csr_row(CSR_ORIGIN_Y, 16'h0000),
         csr_row(CSR_EXTENT_W, 16'd3),
         csr_row(CSR_EXTENT_H, 16'd2),
         req_row(1'b1), req_row(1'b0), req_row(1'b0), req_row(1'b0),
         req_row(1'b0), req_row(1'b0), req_row(1'b0),
         csr_row(CSR_EXTENT_W, 16'd1),                 // short sides act as two
         csr_row(CSR_EXTENT_H, 16'd0),
         req_row(1'b1), req_row(1'b0), req_row(1'b0),
         csr_row(CSR_ORIGIN_X, 16'd5),                 // held point now off the outline
         req_row(1'b0),
         csr_row(CSR_SHAPE_KIND, CSR_DATA_BITS'({KIND_BITS{1'b1}})),
         typed_row(1'b0, 16'd5, 16'h0000, 1'b1),       // unused code walks as a dot
         csr_row(CSR_EXTENT_W, 16'hFFFF),
         csr_row(CSR_EXTENT_H, 16'hFFFF),
         csr_row(CSR_SHAPE_KIND, CSR_DATA_BITS'(SHAPE_RECT)),
         req_row(1'b1), req_row(1'b0)
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].op == ROW_CSR) begin
            wait_drained();
            write_csr(script[i].idx, script[i].val);
         end else begin
            send_request(script[i].restart, script[i].typed, script[i].want);
         end
      end

      stop_at = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < stop_at) begin
         wait_drained();
         calm = (requests_sent >= stop_at - CALM_TAIL) || ($urandom_range(0, 4) == 0);
         retune_shape($urandom_range(0, 2) == 0);
         noisy = ($urandom_range(0, 7) == 0);
         steps = $urandom_range(20, 60);
         for (int k = 0; k < steps; k++) begin
            if (!calm && $urandom_range(0, 5) == 0) idle_requests($urandom_range(1, 13));
            if (noisy || k == 0) restart = $urandom_range(0, 1);
            else                 restart = ($urandom_range(0, 39) == 0);
            send_request(restart, 1'b0, '0);
         end
      end

      wait_drained();
      $display("%0d requests, %0d points checked, %0d register writes, shape codes seen %b",
               requests_sent, points_checked, csr_writes, kinds_seen);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
